// ----- src/rcgs_pkg.sv -----
// Shared constants and helpers for the radial color gradient shader.
package rcgs_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] CFG_BAND_RED   = 3'd0;
	localparam logic [2:0] CFG_BAND_GREEN = 3'd1;
	localparam logic [2:0] CFG_BAND_BLUE  = 3'd2;
	localparam logic [2:0] CFG_GAIN_RED   = 3'd3;
	localparam logic [2:0] CFG_GAIN_GREEN = 3'd4;
	localparam logic [2:0] CFG_GAIN_BLUE  = 3'd5;
	localparam logic [2:0] CFG_PHASE_STEP = 3'd6;

	// Item opcodes
	localparam logic OP_SHADE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Band and channel limits
	localparam int NUM_BANDS_DEF = 8;
	localparam int BAND_SPAN     = 30;
	localparam int PHASE_WRAP    = 240;
	localparam logic [14:0] DIST_MAX = 15'd32767;
	localparam logic [7:0]  CHAN_MAX = 8'd255;

	// Reset values of the registers
	localparam logic [15:0] GAIN_RESET = 16'd256;
	localparam logic [7:0]  STEP_RESET = 8'd5;

	// Reciprocal of the band span: x / 30 == (x * RECIP30) >> RECIP30_SHIFT for x < 32768
	localparam logic [16:0] RECIP30       = 17'd34953;
	localparam int          RECIP30_SHIFT = 20;

	// Shift of the reciprocal used for the band count
	localparam int RECIPN_SHIFT = 16;

	// Pick byte k out of a packed band register
	function automatic logic [7:0] band_byte(input logic [63:0] bytes_v, input logic [2:0] k);
		band_byte = bytes_v[{k, 3'b000} +: 8];
	endfunction

endpackage

// ----- src/radial_color_gradient_shader.sv -----
// Radial color gradient shader: sequencer around one shared multiplier and a root unit.
//
// Usage: a vertex item (op = 0, pos_x/pos_y/pos_z) enters on the in_valid/in_ready
// channel and yields one red/green/blue item on the out_valid/out_ready channel.
// A frame-tick item (op = 1) advances the phase by phase_step in its accept cycle
// and yields no result. Registers are written on cfg_we with cfg_index/cfg_wdata;
// the user must write them only while the block is idle; the block does not enforce it.
// Sequence: a vertex passes from accept through the squares on the shared 17x17
// multiplier, the bit-pair square root, reciprocal division for band and remainder,
// the multiplier steps of each color channel in turn, and the load of the output
// register. A frame tick leaves the sequencer idle.
// A vertex is finished before the next is taken: the single shared multiplier and
// the root recurrence serve one; in_ready is high only while the sequencer is idle.
// The output register parts the two sides: the next vertex is accepted and computed
// while a finished result still waits; if the receiver stalls longer, the sequencer
// holds its finished channels until the output register frees up.
// Reset: phase clears to 0, band registers to 0, gains to 1.0 and phase_step to 5;
// no result is pending after reset.
module radial_color_gradient_shader #(
	parameter int NUM_BANDS = rcgs_pkg::NUM_BANDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	localparam int RECIP_N = ((2 ** rcgs_pkg::RECIPN_SHIFT) + NUM_BANDS - 1) / NUM_BANDS;
	localparam logic [2:0] LAST_BAND = 3'(NUM_BANDS - 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SQ    = 6'b000010,
		ST_ROOT  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_BLEND = 6'b010000,
		ST_WAIT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [3:0]  step_q;
	logic [1:0]  chan_q;

	// Configuration registers
	logic [63:0] band_red_q, band_green_q, band_blue_q;
	logic [15:0] gain_red_q, gain_green_q, gain_blue_q;
	logic signed [7:0] phase_step_q;
	logic [7:0]  phase_q;

	// Datapath registers
	logic [15:0] ax_q, ay_q, az_q;
	logic [31:0] sum_q;
	logic [31:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] bit_q;
	logic [14:0] s_q;
	logic [10:0] q_q;
	logic [4:0]  r_q;
	logic [2:0]  b_q, n_q;
	logic [12:0] acc_q;
	logic [12:0] num_q;
	logic [7:0]  chan_val_q [3];
	logic [33:0] prod_q;

	// Output register
	logic        out_valid_q;
	logic [7:0]  red_q, green_q, blue_q;

	// Combinational datapath
	logic [16:0] mul_a, mul_b;
	logic [31:0] sum_nxt;
	logic [32:0] trial;
	logic [16:0] dist_sum;
	logic [14:0] s_sat;
	logic [10:0] q_nxt;
	logic [15:0] q_times_span;
	logic [15:0] r_full;
	logic [10:0] qn_nxt;
	logic [13:0] qn_times_n;
	logic [10:0] b_full;
	logic [2:0]  b_nxt;
	logic [63:0] band_sel;
	logic [15:0] gain_sel;
	logic [7:0]  band_hi, band_lo;
	logic [7:0]  chan_sat;
	logic signed [9:0] phase_sum;
	logic signed [9:0] phase_nxt;
	logic        in_acc;
	logic        out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

	// Phase advance with a single wrap into 0..240
	always_comb begin
		phase_sum = $signed({2'b00, phase_q}) + 10'(phase_step_q);
		if (phase_sum > 10'sd240) begin
			phase_nxt = phase_sum - 10'(rcgs_pkg::PHASE_WRAP);
		end else if (phase_sum < 10'sd0) begin
			phase_nxt = phase_sum + 10'(rcgs_pkg::PHASE_WRAP);
		end else begin
			phase_nxt = phase_sum;
		end
	end

	// Root step and distance saturation
	assign sum_nxt  = sum_q + prod_q[31:0];
	assign trial    = {1'b0, root_q} + {1'b0, bit_q};
	assign dist_sum = {1'b0, root_q[15:0]} + {9'd0, phase_q};
	assign s_sat    = (dist_sum > {2'b00, rcgs_pkg::DIST_MAX}) ? rcgs_pkg::DIST_MAX
	                                                         : dist_sum[14:0];

	// Quotient and remainder by the band span, then band index modulo the band count
	assign q_nxt        = prod_q[30:20];
	assign q_times_span = {q_nxt, 5'b00000} - {4'd0, q_nxt, 1'b0};
	assign r_full       = {1'b0, s_q} - q_times_span;
	assign qn_nxt       = prod_q[26:16];
	assign qn_times_n   = 14'(qn_nxt * 11'(NUM_BANDS));
	assign b_full       = q_q - qn_times_n[10:0];
	assign b_nxt        = b_full[2:0];

	// Per-channel register selection
	always_comb begin
		case (chan_q)
			2'd0: begin
				band_sel = band_red_q;
				gain_sel = gain_red_q;
			end
			2'd1: begin
				band_sel = band_green_q;
				gain_sel = gain_green_q;
			end
			2'd2: begin
				band_sel = band_blue_q;
				gain_sel = gain_blue_q;
			end
			default: begin
				band_sel = '0;
				gain_sel = '0;
			end
		endcase
	end

	assign band_hi  = rcgs_pkg::band_byte(band_sel, n_q);
	assign band_lo  = rcgs_pkg::band_byte(band_sel, b_q);
	assign chan_sat = (prod_q[33:16] != 18'd0) ? rcgs_pkg::CHAN_MAX : prod_q[15:8];

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ: begin
				case (step_q)
					4'd0: begin
						mul_a = {1'b0, ax_q};
						mul_b = {1'b0, ax_q};
					end
					4'd1: begin
						mul_a = {1'b0, ay_q};
						mul_b = {1'b0, ay_q};
					end
					4'd2: begin
						mul_a = {1'b0, az_q};
						mul_b = {1'b0, az_q};
					end
					default: ;
				endcase
			end
			ST_DIV: begin
				case (step_q)
					4'd0: begin
						mul_a = {2'b00, s_sat};
						mul_b = rcgs_pkg::RECIP30;
					end
					4'd1: begin
						mul_a = {6'd0, q_nxt};
						mul_b = 17'(RECIP_N);
					end
					default: ;
				endcase
			end
			ST_BLEND: begin
				case (step_q)
					4'd0: begin
						mul_a = {9'd0, band_hi};
						mul_b = {12'd0, r_q};
					end
					4'd1: begin
						mul_a = {9'd0, band_lo};
						mul_b = 17'(rcgs_pkg::BAND_SPAN) - {12'd0, r_q};
					end
					4'd3: begin
						mul_a = {4'd0, num_q};
						mul_b = rcgs_pkg::RECIP30;
					end
					4'd4: begin
						mul_a = {9'd0, prod_q[27:20]};
						mul_b = {1'b0, gain_sel};
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Register the product every cycle
	always_ff @(posedge clk) begin
		prod_q <= {17'd0, mul_a} * {17'd0, mul_b};
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_red_q   <= '0;
			band_green_q <= '0;
			band_blue_q  <= '0;
			gain_red_q   <= rcgs_pkg::GAIN_RESET;
			gain_green_q <= rcgs_pkg::GAIN_RESET;
			gain_blue_q  <= rcgs_pkg::GAIN_RESET;
			phase_step_q <= rcgs_pkg::STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rcgs_pkg::CFG_BAND_RED:   band_red_q   <= cfg_wdata;
				rcgs_pkg::CFG_BAND_GREEN: band_green_q <= cfg_wdata;
				rcgs_pkg::CFG_BAND_BLUE:  band_blue_q  <= cfg_wdata;
				rcgs_pkg::CFG_GAIN_RED:   gain_red_q   <= cfg_wdata[15:0];
				rcgs_pkg::CFG_GAIN_GREEN: gain_green_q <= cfg_wdata[15:0];
				rcgs_pkg::CFG_GAIN_BLUE:  gain_blue_q  <= cfg_wdata[15:0];
				rcgs_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Raise the result when loaded, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WAIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			chan_q      <= '0;
			phase_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == rcgs_pkg::OP_TICK) begin
							phase_q <= phase_nxt[7:0];
						end else begin
							state_q <= ST_SQ;
							step_q  <= '0;
						end
					end
				end
				ST_SQ: begin
					if (step_q == 4'd3) begin
						state_q <= ST_ROOT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_ROOT: begin
					if (step_q == 4'd15) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DIV: begin
					if (step_q == 4'd2) begin
						state_q <= ST_BLEND;
						step_q  <= '0;
						chan_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_BLEND: begin
					if (step_q == 4'd5) begin
						step_q <= '0;
						if (chan_q == 2'd2) begin
							state_q <= ST_WAIT;
						end else begin
							chan_q <= chan_q + 2'd1;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, advanced by the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// latch magnitudes and clear the accumulator
				if (in_acc) begin
					ax_q  <= pos_x[15] ? (~pos_x + 16'd1) : pos_x;
					ay_q  <= pos_y[15] ? (~pos_y + 16'd1) : pos_y;
					az_q  <= pos_z[15] ? (~pos_z + 16'd1) : pos_z;
					sum_q <= '0;
				end
			end
			ST_SQ: begin
				// accumulate squares from the registered product
				if (step_q != 4'd0) begin
					sum_q <= sum_nxt;
				end
				if (step_q == 4'd3) begin
					rem_q  <= sum_nxt;
					root_q <= '0;
					bit_q  <= 32'h4000_0000;
				end
			end
			ST_ROOT: begin
				// one bit pair of the root per cycle
				if ({1'b0, rem_q} >= trial) begin
					rem_q  <= rem_q - trial[31:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIV: begin
				case (step_q)
					4'd0: s_q <= s_sat;
					4'd1: begin
						q_q <= q_nxt;
						r_q <= r_full[4:0];
					end
					4'd2: begin
						b_q <= b_nxt;
						n_q <= (b_nxt == LAST_BAND) ? 3'd0 : b_nxt + 3'd1;
					end
					default: ;
				endcase
			end
			ST_BLEND: begin
				case (step_q)
					4'd1: acc_q <= prod_q[12:0];
					4'd2: num_q <= acc_q + prod_q[12:0];
					4'd5: chan_val_q[chan_q] <= chan_sat;
					default: ;
				endcase
			end
			ST_WAIT: begin
				// load the output register once it is free
				if (out_free) begin
					red_q   <= chan_val_q[0];
					green_q <= chan_val_q[1];
					blue_q  <= chan_val_q[2];
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= 8'(rcgs_pkg::PHASE_WRAP))
		else $error("phase left its wrap range");

	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> $onehot(bit_q))
		else $error("root trial bit is not a single bit");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLEND) |-> (b_q <= LAST_BAND && n_q <= LAST_BAND))
		else $error("band index beyond band count");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLEND) |-> (r_q < 5'(rcgs_pkg::BAND_SPAN)))
		else $error("span remainder out of range");

	a_shade_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == rcgs_pkg::OP_SHADE) |=> (state_q == ST_SQ && step_q == 4'd0))
		else $error("vertex item did not start the sequencer");
`endif

endmodule
